@@ hdl/bhp_pkg.sv @@
// Package for the bitstream header parser: beat types, status and error codes.
`default_nettype none
package bhp_pkg;

    localparam int unsigned MAX_HEADER_DEF = 1024;
    localparam int unsigned HLEN_W         = 11;
    localparam int unsigned BLEN_W         = 32;

    localparam logic [1:0] ST_PARSING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_MAGIC    = 3'd1;
    localparam logic [2:0] ERR_VERSION  = 3'd2;
    localparam logic [2:0] ERR_KEY      = 3'd3;
    localparam logic [2:0] ERR_NO_NULL  = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG = 3'd5;

    localparam logic [7:0] MAGIC_EVEN = 8'h0f;
    localparam logic [7:0] MAGIC_ODD  = 8'hf0;
    localparam logic [7:0] KEY_A      = 8'h61;
    localparam logic [2:0] KEY_E_IDX  = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [2:0]        error_kind;
        logic [HLEN_W-1:0] header_length;
        logic [BLEN_W-1:0] bitstream_length;
    } out_beat_t;

endpackage
`default_nettype wire

@@ hdl/bitstream_header_parser.sv @@
// Bitstream header parser: byte-serial header checker with registered result beat.
//
// Input channel s_*: one header byte per beat; s_data.first restarts parsing
// with that byte as header byte zero. Result channel m_*: one beat per input
// beat carrying status, error kind, header length and bitstream length.
// The result for a byte is registered at its accept edge and shows on m_* in
// the next cycle. Throughput is one byte per cycle unless m_ready stalls; the
// parse state updates in one step per byte in a single register stage.
// s_ready is high whenever the result register is empty or being taken, so a
// stalled m_ready stalls the input after one held result.
// Reset clears the parse state as for a restart and empties the result
// register. After completion or error the held status repeats until a byte
// with first set arrives. A byte arriving after MAX_HEADER bytes have been
// consumed ends parsing with a too-long error.
`default_nettype none
module bitstream_header_parser
    import bhp_pkg::*;
#(
    parameter int unsigned MAX_HEADER = MAX_HEADER_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    localparam int unsigned BCW = $clog2(MAX_HEADER + 1);

    localparam logic [3:0] PH_MLEN_HI   = 4'd0;
    localparam logic [3:0] PH_MLEN_LO   = 4'd1;
    localparam logic [3:0] PH_MAGIC     = 4'd2;
    localparam logic [3:0] PH_MAGIC_END = 4'd3;
    localparam logic [3:0] PH_VER_HI    = 4'd4;
    localparam logic [3:0] PH_VER_LO    = 4'd5;
    localparam logic [3:0] PH_KEY       = 4'd6;
    localparam logic [3:0] PH_FLEN_HI   = 4'd7;
    localparam logic [3:0] PH_FLEN_LO   = 4'd8;
    localparam logic [3:0] PH_PAYLOAD   = 4'd9;
    localparam logic [3:0] PH_BLEN      = 4'd10;
    localparam logic [3:0] PH_HELD      = 4'd11;

    logic [3:0]        phase_reg, phase_next, phase_cur;
    logic [15:0]       remaining_reg, remaining_next, remaining_cur;
    logic              magic_odd_reg, magic_odd_next, magic_odd_cur;
    logic [2:0]        field_key_reg, field_key_next, field_key_cur;
    logic [BCW-1:0]    byte_count_reg, byte_count_next, byte_count_cur;
    logic [BLEN_W-1:0] accum_reg, accum_next, accum_cur;
    logic [1:0]        status_reg, status_next, status_cur;
    logic [2:0]        error_reg, error_next, error_cur;
    logic [HLEN_W-1:0] hlen_reg, hlen_next, hlen_cur;
    logic [BLEN_W-1:0] blen_reg, blen_next, blen_cur;

    logic              m_valid_reg;
    out_beat_t         m_data_reg;
    logic              accept;
    logic              fail;
    logic [2:0]        fail_kind;
    logic [15:0]       len16;
    logic [15:0]       rem_dec;
    logic [7:0]        b;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign b       = s_data.data_byte;

    // restart selects the reset state as the starting point
    always_comb begin
        if (s_data.first) begin
            phase_cur      = PH_MLEN_HI;
            remaining_cur  = '0;
            magic_odd_cur  = 1'b0;
            field_key_cur  = '0;
            byte_count_cur = '0;
            accum_cur      = '0;
            status_cur     = ST_PARSING;
            error_cur      = ERR_NONE;
            hlen_cur       = '0;
            blen_cur       = '0;
        end else begin
            phase_cur      = phase_reg;
            remaining_cur  = remaining_reg;
            magic_odd_cur  = magic_odd_reg;
            field_key_cur  = field_key_reg;
            byte_count_cur = byte_count_reg;
            accum_cur      = accum_reg;
            status_cur     = status_reg;
            error_cur      = error_reg;
            hlen_cur       = hlen_reg;
            blen_cur       = blen_reg;
        end
    end

    always_comb begin
        phase_next      = phase_cur;
        remaining_next  = remaining_cur;
        magic_odd_next  = magic_odd_cur;
        field_key_next  = field_key_cur;
        byte_count_next = byte_count_cur;
        accum_next      = accum_cur;
        status_next     = status_cur;
        error_next      = error_cur;
        hlen_next       = hlen_cur;
        blen_next       = blen_cur;
        fail            = 1'b0;
        fail_kind       = ERR_NONE;
        len16           = remaining_cur | {8'd0, b};
        rem_dec         = remaining_cur - 16'd1;

        if (phase_cur != PH_HELD) begin
            if (byte_count_cur >= BCW'(MAX_HEADER)) begin
                fail      = 1'b1;
                fail_kind = ERR_TOO_LONG;
            end else begin
                byte_count_next = byte_count_cur + BCW'(1);
                case (phase_cur)
                    PH_MLEN_HI: begin
                        remaining_next = {b, 8'd0};
                        phase_next     = PH_MLEN_LO;
                    end
                    PH_MLEN_LO: begin
                        if (len16 == 16'd0) begin
                            fail      = 1'b1;
                            fail_kind = ERR_MAGIC;
                        end else begin
                            remaining_next = len16 - 16'd1;
                            magic_odd_next = 1'b0;
                            phase_next     = (len16 == 16'd1) ? PH_MAGIC_END : PH_MAGIC;
                        end
                    end
                    PH_MAGIC: begin
                        if (b != (magic_odd_cur ? MAGIC_ODD : MAGIC_EVEN)) begin
                            fail      = 1'b1;
                            fail_kind = ERR_MAGIC;
                        end else begin
                            magic_odd_next = !magic_odd_cur;
                            remaining_next = rem_dec;
                            if (rem_dec == 16'd0) begin
                                phase_next = PH_MAGIC_END;
                            end
                        end
                    end
                    PH_MAGIC_END: begin
                        phase_next = PH_VER_HI;
                    end
                    PH_VER_HI: begin
                        accum_next = {24'd0, b};
                        phase_next = PH_VER_LO;
                    end
                    PH_VER_LO: begin
                        if (accum_cur != '0 || b != 8'h01) begin
                            fail      = 1'b1;
                            fail_kind = ERR_VERSION;
                        end else begin
                            accum_next = '0;
                            phase_next = PH_KEY;
                        end
                    end
                    PH_KEY: begin
                        if (field_key_cur > KEY_E_IDX || b != KEY_A + {5'd0, field_key_cur}) begin
                            fail      = 1'b1;
                            fail_kind = ERR_KEY;
                        end else if (field_key_cur == KEY_E_IDX) begin
                            remaining_next = 16'd4;
                            accum_next     = '0;
                            phase_next     = PH_BLEN;
                        end else begin
                            phase_next = PH_FLEN_HI;
                        end
                    end
                    PH_FLEN_HI: begin
                        remaining_next = {b, 8'd0};
                        phase_next     = PH_FLEN_LO;
                    end
                    PH_FLEN_LO: begin
                        if (len16 == 16'd0) begin
                            fail      = 1'b1;
                            fail_kind = ERR_NO_NULL;
                        end else begin
                            remaining_next = len16;
                            phase_next     = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        remaining_next = rem_dec;
                        if (rem_dec == 16'd0) begin
                            if (b != 8'd0) begin
                                fail      = 1'b1;
                                fail_kind = ERR_NO_NULL;
                            end else begin
                                field_key_next = field_key_cur + 3'd1;
                                phase_next     = PH_KEY;
                            end
                        end
                    end
                    PH_BLEN: begin
                        accum_next     = {accum_cur[BLEN_W-9:0], b};
                        remaining_next = rem_dec;
                        if (rem_dec == 16'd0) begin
                            phase_next  = PH_HELD;
                            status_next = ST_DONE;
                            error_next  = ERR_NONE;
                            hlen_next   = HLEN_W'(byte_count_cur + BCW'(1));
                            blen_next   = {accum_cur[BLEN_W-9:0], b};
                        end
                    end
                    default: begin
                        phase_next = PH_HELD;
                    end
                endcase
            end
        end

        if (fail) begin
            phase_next  = PH_HELD;
            status_next = ST_ERROR;
            error_next  = fail_kind;
            hlen_next   = '0;
            blen_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_MLEN_HI;
            remaining_reg  <= '0;
            magic_odd_reg  <= 1'b0;
            field_key_reg  <= '0;
            byte_count_reg <= '0;
            accum_reg      <= '0;
            status_reg     <= ST_PARSING;
            error_reg      <= ERR_NONE;
            hlen_reg       <= '0;
            blen_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg      <= phase_next;
                remaining_reg  <= remaining_next;
                magic_odd_reg  <= magic_odd_next;
                field_key_reg  <= field_key_next;
                byte_count_reg <= byte_count_next;
                accum_reg      <= accum_next;
                status_reg     <= status_next;
                error_reg      <= error_next;
                hlen_reg       <= hlen_next;
                blen_reg       <= blen_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.status           <= status_next;
            m_data_reg.error_kind       <= error_next;
            m_data_reg.header_length    <= hlen_next;
            m_data_reg.bitstream_length <= blen_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= BCW'(MAX_HEADER))
        else $error("byte count past header limit");

    a_error_lengths: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_ERROR |->
            m_data.header_length == '0 && m_data.bitstream_length == '0
            && m_data.error_kind != ERR_NONE)
        else $error("error beat with lengths or no kind");

    a_parsing_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_PARSING |->
            m_data.error_kind == ERR_NONE && m_data.header_length == '0)
        else $error("parsing beat carries result fields");

    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_DONE |-> m_data.error_kind == ERR_NONE)
        else $error("complete beat with error kind");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !$past(accept) |-> $stable(m_data))
        else $error("result changed without an input beat");

endmodule
`default_nettype wire
